### sv/rmv_pkg.sv
// ----------------------------------------------------------------------------
// rmv_pkg: shared types and constants for the running mean/variance unit
// Field widths of the request and response channels and the divider
// control and status structs.
// ----------------------------------------------------------------------------
package rmv_pkg;

   // request / response field widths
   localparam int SAMPLE_W = 32;
   localparam int COUNT_W  = 16;
   localparam int MEAN_W   = 32;
   localparam int M2_W     = 63;

   // shared divider: dividend/quotient width and step counter width
   localparam int DIV_W      = 63;
   localparam int DIV_STEP_W = 6;

   localparam logic [M2_W-1:0] M2_MAX = {M2_W{1'b1}};

   typedef struct packed {
      logic                  start;
      logic [DIV_STEP_W-1:0] steps;
   } div_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

### sv/rmv_if.sv
// ----------------------------------------------------------------------------
// rmv_if: request and response channels of the running mean/variance unit
// Valid/ready channels; a request moves at a clock edge with both high.
// ----------------------------------------------------------------------------
interface rmv_req_if;
   import rmv_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       restart;

   modport source (output valid, output sample, output restart, input ready);
   modport sink   (input valid, input sample, input restart, output ready);
endinterface

interface rmv_rsp_if;
   import rmv_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [COUNT_W-1:0]       count;
   logic signed [MEAN_W-1:0] mean_value;
   logic [M2_W-1:0]          sum_sq_dev;
   logic [M2_W-1:0]          variance;
   logic                     variance_valid;
   logic                     saturated;

   modport source (output valid, output count, output mean_value, output sum_sq_dev,
                   output variance, output variance_valid, output saturated,
                   input ready);
   modport sink   (input valid, input count, input mean_value, input sum_sq_dev,
                   input variance, input variance_valid, input saturated,
                   output ready);
endinterface

### sv/rmv_div.sv
// ----------------------------------------------------------------------------
// rmv_div: shared iterative unsigned divider
// Restoring division, one quotient bit per cycle. The dividend is taken
// left-aligned; after N steps the quotient sits in the low N bits.
// ----------------------------------------------------------------------------
module rmv_div #(
   parameter int DIVISOR_W = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  rmv_pkg::div_req_type        ctrl,
   input  logic [rmv_pkg::DIV_W-1:0]   dividend,
   input  logic [DIVISOR_W-1:0]        divisor,
   output rmv_pkg::div_stat_type       status,
   output logic [rmv_pkg::DIV_W-1:0]   quotient
);
   import rmv_pkg::*;

   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]      quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [DIV_STEP_W-1:0] left_ff, left_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   logic [DIVISOR_W:0] shifted_w;
   logic [DIVISOR_W:0] diff_w;
   logic               take_w;

   assign shifted_w = {rem_ff, quo_ff[DIV_W-1]};
   assign diff_w    = shifted_w - {1'b0, dvs_ff};
   assign take_w    = shifted_w >= {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      left_in = left_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctrl.start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         left_in = ctrl.steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = take_w ? diff_w[DIVISOR_W-1:0] : shifted_w[DIVISOR_W-1:0];
         quo_in  = {quo_ff[DIV_W-2:0], take_w};
         left_in = left_ff - DIV_STEP_W'(1);
         if (left_ff == DIV_STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         left_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         left_ff <= left_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

### sv/running_mean_variance_unit.sv
// ----------------------------------------------------------------------------
// running_mean_variance_unit: streaming Welford mean and variance
// Keeps count, mean and M2 over signed fixed-point samples and returns
// count, mean, M2 and sample variance M2/(n-1) for every request.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ch carries one sample (low SAMPLE_WIDTH bits used, two's complement)
//    and a restart flag that clears count, mean and M2 before the sample.
//  - rsp_ch returns one response per request: count, mean, M2 (Q31.32),
//    variance (zero and variance_valid low while count < 2), saturated.
//  - One request is in work at a time; req_ch.ready is high only when the
//    sequencer is idle. Each request makes two passes through the shared
//    one-bit-per-cycle divider (SAMPLE_WIDTH steps for the mean step, 63
//    steps for the variance), with sequencer states around them. With
//    fewer than two samples, or at a held full count, the divider passes
//    that are not needed are skipped.
//  - Results sit in an output register; a new request is taken while a
//    response waits, and the sequencer only holds in its final state if a
//    second response is ready before the first one has been taken.
//  - At full count without restart the state is held and saturated is set.
//  - Reset (synchronous) clears count, mean and M2 and drops any response.
// ----------------------------------------------------------------------------
module running_mean_variance_unit #(
   parameter int COUNT_WIDTH  = 16,
   parameter int SAMPLE_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   rmv_req_if.sink    req_ch,
   rmv_rsp_if.source  rsp_ch
);
   import rmv_pkg::*;

   localparam int SW     = SAMPLE_WIDTH;
   localparam int CW     = COUNT_WIDTH;
   localparam int PROD_W = 2 * SAMPLE_WIDTH;
   localparam int SUM_W  = M2_W + 2;

   localparam logic [DIV_STEP_W-1:0] STEPS_MEAN = DIV_STEP_W'(SAMPLE_WIDTH);
   localparam logic [DIV_STEP_W-1:0] STEPS_VAR  = DIV_STEP_W'(DIV_W);

   // sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;  // wait for a request
   localparam logic [2:0] S_STEP   = 3'd1;  // mean step division running
   localparam logic [2:0] S_MUL    = 3'd2;  // delta * (x - new mean)
   localparam logic [2:0] S_ACC    = 3'd3;  // saturating M2 accumulate
   localparam logic [2:0] S_VSTART = 3'd4;  // launch variance division
   localparam logic [2:0] S_VAR    = 3'd5;  // variance division running
   localparam logic [2:0] S_DONE   = 3'd6;  // hand result to output register

   logic [2:0]            state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic signed [SW-1:0]  mean_ff, mean_in;
   logic [M2_W-1:0]       m2_ff, m2_in;
   logic signed [SW-1:0]  x_ff, x_in;
   logic                  dneg_ff, dneg_in;
   logic [SW-1:0]         dmag_ff, dmag_in;
   logic                  sat_ff, sat_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [M2_W-1:0]       var_ff, var_in;

   // output register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]       o_count_ff, o_count_in;
   logic signed [MEAN_W-1:0] o_mean_ff, o_mean_in;
   logic [M2_W-1:0]          o_m2_ff, o_m2_in;
   logic [M2_W-1:0]          o_var_ff, o_var_in;
   logic                     o_vv_ff, o_vv_in;
   logic                     o_sat_ff, o_sat_in;

   // divider hookup
   div_req_type        div_ctrl;
   div_stat_type       div_stat;
   logic [DIV_W-1:0]   div_dividend;
   logic [CW-1:0]      div_divisor;
   logic [DIV_W-1:0]   div_quotient;

   // request side arithmetic
   logic                 req_fire_w;
   logic signed [SW-1:0] x_w;
   logic [CW-1:0]        cnt_eff_w;
   logic signed [SW-1:0] mean_eff_w;
   logic                 full_w;
   logic signed [SW:0]   delta_w;
   logic [SW:0]          dabs_w;

   // update arithmetic
   logic [SW-1:0]        q_w;
   logic signed [SW:0]   step_w;
   logic signed [SW:0]   nmean_w;
   logic signed [SW:0]   diff_w;
   logic [SW:0]          diff_abs_w;
   logic [PROD_W-1:0]    prod_w;
   logic [SUM_W-1:0]     sum_w;
   logic                 two_plus_w;
   logic                 out_free_w;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire_w   = req_ch.valid && req_ch.ready;

   // restart clears the running state before the sample is applied
   assign x_w        = $signed(req_ch.sample[SW-1:0]);
   assign cnt_eff_w  = req_ch.restart ? '0 : count_ff;
   assign mean_eff_w = req_ch.restart ? '0 : mean_ff;
   assign full_w     = &cnt_eff_w;

   // delta = x - old mean, kept as sign and magnitude for the divider
   assign delta_w = (SW+1)'(x_w) - (SW+1)'(mean_eff_w);
   assign dabs_w  = delta_w[SW] ? -delta_w : delta_w;

   // truncating signed step: magnitude quotient, sign of delta
   assign q_w     = div_quotient[SW-1:0];
   assign step_w  = dneg_ff ? -$signed({1'b0, q_w}) : $signed({1'b0, q_w});
   assign nmean_w = (SW+1)'(mean_ff) + step_w;

   // x - new mean has the sign of delta, so magnitudes multiply to M2 term
   assign diff_w     = (SW+1)'(x_ff) - (SW+1)'(mean_ff);
   assign diff_abs_w = diff_w[SW] ? -diff_w : diff_w;
   assign prod_w     = dmag_ff * diff_abs_w[SW-1:0];

   assign sum_w = SUM_W'(prod_ff) + SUM_W'(m2_ff);

   assign two_plus_w = count_ff >= CW'(2);
   assign out_free_w = !rsp_valid_ff || rsp_ch.ready;

   // divider: mean step from idle, variance from S_VSTART
   always_comb begin
      div_ctrl.start = 1'b0;
      div_ctrl.steps = STEPS_VAR;
      div_dividend   = m2_ff;
      div_divisor    = count_ff - CW'(1);
      if (state_ff == S_IDLE) begin
         div_ctrl.start = req_fire_w && !full_w;
         div_ctrl.steps = STEPS_MEAN;
         div_dividend   = {dabs_w[SW-1:0], {(DIV_W-SW){1'b0}}};
         div_divisor    = cnt_eff_w + CW'(1);
      end else if (state_ff == S_VSTART) begin
         div_ctrl.start = two_plus_w;
      end
   end

   rmv_div #(
      .DIVISOR_W (CW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .status   (div_stat),
      .quotient (div_quotient)
   );

   // sequencer and datapath
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      mean_in      = mean_ff;
      m2_in        = m2_ff;
      x_in         = x_ff;
      dneg_in      = dneg_ff;
      dmag_in      = dmag_ff;
      sat_in       = sat_ff;
      prod_in      = prod_ff;
      var_in       = var_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      o_count_in   = o_count_ff;
      o_mean_in    = o_mean_ff;
      o_m2_in      = o_m2_ff;
      o_var_in     = o_var_ff;
      o_vv_in      = o_vv_ff;
      o_sat_in     = o_sat_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire_w) begin
               if (req_ch.restart) begin
                  count_in = '0;
                  mean_in  = '0;
                  m2_in    = '0;
               end
               x_in    = x_w;
               dneg_in = delta_w[SW];
               dmag_in = dabs_w[SW-1:0];
               sat_in  = full_w;
               // full count: hold state, report it with saturated set
               state_in = full_w ? S_VSTART : S_STEP;
            end
         end
         S_STEP: begin
            if (div_stat.done) begin
               mean_in  = nmean_w[SW-1:0];
               count_in = count_ff + CW'(1);
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in  = prod_w;
            state_in = S_ACC;
         end
         S_ACC: begin
            // clamp M2 at its largest value on overflow
            m2_in    = (sum_w > SUM_W'(M2_MAX)) ? M2_MAX : sum_w[M2_W-1:0];
            state_in = S_VSTART;
         end
         S_VSTART: begin
            if (two_plus_w) begin
               state_in = S_VAR;
            end else begin
               var_in   = '0;
               state_in = S_DONE;
            end
         end
         S_VAR: begin
            if (div_stat.done) begin
               var_in   = div_quotient[M2_W-1:0];
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free_w) begin
               rsp_valid_in = 1'b1;
               o_count_in   = COUNT_W'(count_ff);
               o_mean_in    = MEAN_W'(mean_ff);
               o_m2_in      = m2_ff;
               o_var_in     = var_ff;
               o_vv_in      = two_plus_w;
               o_sat_in     = sat_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         mean_ff      <= '0;
         m2_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         mean_ff      <= mean_in;
         m2_ff        <= m2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff       <= x_in;
      dneg_ff    <= dneg_in;
      dmag_ff    <= dmag_in;
      sat_ff     <= sat_in;
      prod_ff    <= prod_in;
      var_ff     <= var_in;
      o_count_ff <= o_count_in;
      o_mean_ff  <= o_mean_in;
      o_m2_ff    <= o_m2_in;
      o_var_ff   <= o_var_in;
      o_vv_ff    <= o_vv_in;
      o_sat_ff   <= o_sat_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.count          = o_count_ff;
   assign rsp_ch.mean_value     = o_mean_ff;
   assign rsp_ch.sum_sq_dev     = o_m2_ff;
   assign rsp_ch.variance       = o_var_ff;
   assign rsp_ch.variance_valid = o_vv_ff;
   assign rsp_ch.saturated      = o_sat_ff;

endmodule

### bench/running_mean_variance_unit_test.sv
// ----------------------------------------------------------------------------
// running_mean_variance_unit_test: self-checking bench for the Welford unit
// Drives signed Q16.16 samples with restarts into the unit, predicts count,
// mean, M2, variance and the flags per request, and checks every response in
// order. Random stalls on both channels, one long response hold-off, and
// long sequences at the default count width.
// ----------------------------------------------------------------------------
module running_mean_variance_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import rmv_pkg::*;

   // Default 16-bit count; the full-count hold lies far beyond the run, so
   // long sequences stand in for it.
   localparam int CNT_W       = COUNT_W;
   localparam int CNT_MAX     = (1 << CNT_W) - 1;
   localparam int LONG_SEQ    = 64;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int DRAIN_WAIT  = 150;   // longer than one request takes
   localparam int HOLD_CYCLES = 600;

   localparam bit [63:0] M2_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

   // sample selection modes for random sequences
   typedef enum int {
      PICK_ANY,
      PICK_NEAR,
      PICK_EXTREME,
      PICK_WIDE
   } pick_mode_type;

   // one predicted response
   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [MEAN_W-1:0]  mean_value;
      logic [M2_W-1:0]    sum_sq_dev;
      logic [M2_W-1:0]    variance;
      logic               variance_valid;
      logic               saturated;
   } stats_type;

   logic clock;
   logic reset;

   rmv_req_if req_ch ();
   rmv_rsp_if rsp_ch ();

   running_mean_variance_unit #(
      .COUNT_WIDTH  (CNT_W),
      .SAMPLE_WIDTH (SAMPLE_W)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // predicted statistics, oldest first
   stats_type pending_stats[$];

   // predictor copy of the running sequence
   int     seq_count;
   longint seq_mean;
   bit [63:0] seq_m2;

   int errors;
   int cycle_count;
   int hold_left;
   bit idle_on;

   // ------------------------------------------------------------------------
   // clock, watchdog
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Welford predictor: applies one accepted request to the predictor state
   // and returns the response it must produce.
   // ------------------------------------------------------------------------
   function automatic stats_type welford_update(input logic signed [SAMPLE_W-1:0] smp,
                                                 input logic rst);
      stats_type r;
      longint    x;
      longint    delta;
      longint    nmean;
      int        n;
      bit [63:0] mag_delta;
      bit [63:0] mag_resid;
      bit [63:0] prod;
      bit [63:0] divisor;
      bit [63:0] quotient;

      x = longint'(smp);
      r = '0;
      if (rst) begin
         seq_count = 0;
         seq_mean  = 0;
         seq_m2    = '0;
      end

      if (seq_count >= CNT_MAX) begin
         // full count: state held, sample dropped
         r.saturated = 1'b1;
      end else begin
         n     = seq_count + 1;
         delta = x - seq_mean;
         // signed divide truncates toward zero
         nmean = seq_mean + delta / n;
         if (n > 1) begin
            // delta and x - new mean share a sign, so magnitudes suffice
            mag_delta = (delta < 0) ? -delta : delta;
            mag_resid = ((x - nmean) < 0) ? -(x - nmean) : (x - nmean);
            prod      = mag_delta * mag_resid;
            if (prod > M2_LIMIT - seq_m2)
               seq_m2 = M2_LIMIT;
            else
               seq_m2 = seq_m2 + prod;
         end else begin
            seq_m2 = '0;
         end
         seq_mean  = nmean;
         seq_count = n;
      end

      r.count          = COUNT_W'(seq_count);
      r.mean_value     = seq_mean[MEAN_W-1:0];
      r.sum_sq_dev     = seq_m2[M2_W-1:0];
      r.variance_valid = (seq_count >= 2);
      if (r.variance_valid) begin
         divisor    = seq_count - 1;
         quotient   = seq_m2 / divisor;
         r.variance = quotient[M2_W-1:0];
      end
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // request driver: optional idle burst, then one request held until taken.
   // valid stays high across back-to-back requests; only data changes.
   // ------------------------------------------------------------------------
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp, input logic rst);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      @(negedge clock);
      req_ch.valid   <= 1'b1;
      req_ch.sample  <= smp;
      req_ch.restart <= rst;
      do @(posedge clock); while (!req_ch.ready);
      pending_stats.push_back(welford_update(smp, rst));
   endtask

   // sample source for random sequences
   function automatic logic signed [SAMPLE_W-1:0] pick_sample(
         input logic signed [SAMPLE_W-1:0] center, input pick_mode_type mode);
      case (mode)
         PICK_NEAR: begin
            return center + SAMPLE_W'($urandom_range(0, 2047)) - 1024;
         end
         PICK_WIDE: begin
            return center + SAMPLE_W'($urandom_range(0, 32'h001F_FFFF)) - 32'h0010_0000;
         end
         PICK_EXTREME: begin
            case ($urandom_range(0, 4))
               0:       return 32'sh7FFF_FFFF;
               1:       return 32'sh8000_0000;
               2:       return '0;
               3:       return -1;
               default: return center;
            endcase
         end
         default: begin
            return $urandom;
         end
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // response side: random stall bursts, plus the long hold-off while
   // hold_left runs down in its own cycle counter
   // ------------------------------------------------------------------------
   initial begin
      int stall;
      stall = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0 || stall > 0) begin
            rsp_ch.ready <= 1'b0;
            if (stall > 0) stall--;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            // ready drops now and stays low while stall runs down
            stall = $urandom_range(0, 18);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (hold_left > 0) hold_left--;
   end

   // ------------------------------------------------------------------------
   // response checker: each taken response against the oldest prediction
   // ------------------------------------------------------------------------
   task automatic check_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin : rsp_check
      stats_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_stats.size() == 0) begin
            errors++;
            $display("%0t: response with no request outstanding, count %h mean %h",
                     $time, rsp_ch.count, rsp_ch.mean_value);
         end else begin
            want = pending_stats.pop_front();
            check_field("count", want.count, rsp_ch.count);
            check_field("mean_value", want.mean_value, $unsigned(rsp_ch.mean_value));
            check_field("sum_sq_dev", want.sum_sq_dev, rsp_ch.sum_sq_dev);
            check_field("variance", want.variance, rsp_ch.variance);
            check_field("variance_valid", want.variance_valid, rsp_ch.variance_valid);
            check_field("saturated", want.saturated, rsp_ch.saturated);
         end
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // First sample straight out of reset (no restart), then the sample extremes,
   // a restart, and a repeated value that must leave M2 at zero.
   task automatic test_first_sample_extremes();
      send_sample(32'sh7FFF_FFFF, 1'b0);
      send_sample(32'sh8000_0000, 1'b0);
      send_sample('0, 1'b0);
      send_sample(-1, 1'b0);
      send_sample(1, 1'b0);
      send_sample(32'sh8000_0000, 1'b1);
      send_sample(32'sh8000_0000, 1'b0);
   endtask

   // Alternating full-scale samples: the second product already pushes M2
   // past its range, so M2 must clamp and stay clamped.
   task automatic test_m2_overflow();
      send_sample(32'sh7FFF_FFFF, 1'b1);
      for (int k = 0; k < 5; k++)
         send_sample((k % 2 == 0) ? 32'sh8000_0000 : 32'sh7FFF_FFFF, 1'b0);
   endtask

   // Small mixed-sign values: mean steps of negative deltas truncate toward
   // zero, not toward minus infinity.
   task automatic test_truncation_signs();
      send_sample(3, 1'b1);
      send_sample(-4, 1'b0);
      send_sample(5, 1'b0);
      send_sample(-6, 1'b0);
      send_sample(2, 1'b0);
   endtask

   // One long sequence so the count and the variance divisor grow, then a
   // restart after it and one more sample.
   task automatic test_long_sequence();
      logic signed [SAMPLE_W-1:0] center;
      center = $urandom;
      send_sample(pick_sample(center, PICK_WIDE), 1'b1);
      for (int k = 1; k < LONG_SEQ; k++)
         send_sample(pick_sample(center, PICK_WIDE), 1'b0);
      send_sample(pick_sample(center, PICK_ANY), 1'b1);
      send_sample(pick_sample(center, PICK_ANY), 1'b0);
   endtask

   // Hold responses off for a long stretch while requests keep coming, so
   // the output register fills and the unit stops taking requests.
   task automatic test_backpressure();
      logic signed [SAMPLE_W-1:0] base;
      base = $urandom;
      @(negedge clock);
      hold_left = HOLD_CYCLES;
      for (int k = 0; k < 8; k++)
         send_sample(base + k * 4096, k == 0);
   endtask

   // Random sequences: mostly a restart followed by samples picked with one
   // mode and center; some run long, some skip the restart, and stray restarts
   // land mid-sequence.
   task automatic test_random_sequences(input int items);
      int            sent;
      int            len;
      logic          rst;
      pick_mode_type mode;
      logic signed [SAMPLE_W-1:0] center;
      sent = 0;
      while (sent < items) begin
         len    = ($urandom_range(0, 3) == 0) ? $urandom_range(LONG_SEQ - 3, LONG_SEQ + 9)
                                              : $urandom_range(1, 16);
         center = $urandom;
         mode   = pick_mode_type'($urandom_range(0, 3));
         for (int k = 0; k < len && sent < items; k++) begin
            rst = (k == 0 && $urandom_range(0, 9) != 0) || $urandom_range(0, 49) == 0;
            send_sample(pick_sample(center, mode), rst);
            sent++;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      errors         = 0;
      hold_left      = 0;
      idle_on        = 1'b1;
      seq_count      = 0;
      seq_mean       = 0;
      seq_m2         = '0;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.sample  = '0;
      req_ch.restart = 1'b0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_first_sample_extremes();
      test_m2_overflow();
      test_truncation_signs();
      test_long_sequence();
      test_backpressure();
      test_random_sequences(620);

      // closing stretch at full rate on both channels
      idle_on = 1'b0;
      test_random_sequences(100);

      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_stats.size() != 0) @(posedge clock);
      // catch stray responses after the last expected one
      repeat (DRAIN_WAIT) @(posedge clock);

      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
